@@ rtl/image_border_padding_top_defines.svh @@
// ----------------------------------------------------------------------------
// image_border_padding_top_defines
// Assertion macros for the image border padding RTL, used by ibp_queue.
// ----------------------------------------------------------------------------
`ifndef IMAGE_BORDER_PADDING_TOP_DEFINES_SVH
`define IMAGE_BORDER_PADDING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IBP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ibp assertion failed");
`define IBP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("ibp assertion failed");
`else
`define IBP_ASSERT(lbl, prop)
`define IBP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/ibp_pkg.sv @@
// ----------------------------------------------------------------------------
// ibp_pkg
// Constants, codes and shared types of the image border padding block.
// ----------------------------------------------------------------------------
package ibp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PIXEL_BITS  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
    localparam int K_BITS    = ((DIM_BITS > 10) ? DIM_BITS : 10) + 2;
    localparam int ADDR_BITS = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

    localparam int SIZE_BITS     = 9;
    localparam int PAD_BITS      = 8;
    localparam int MODE_BITS     = 2;
    localparam int IDX_BITS      = 10;
    localparam int PIX_PORT_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_CONSTANT  = 2'd0,
        MODE_REPLICATE = 2'd1,
        MODE_REFLECT   = 2'd2,
        MODE_WRAP      = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_PAD_TOP      = 3'd2,
        REG_PAD_BOTTOM   = 3'd3,
        REG_PAD_LEFT     = 3'd4,
        REG_PAD_RIGHT    = 3'd5,
        REG_BORDER_MODE  = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [SIZE_BITS-1:0] image_width;
        logic [SIZE_BITS-1:0] image_height;
        logic [PAD_BITS-1:0]  pad_top;
        logic [PAD_BITS-1:0]  pad_bottom;
        logic [PAD_BITS-1:0]  pad_left;
        logic [PAD_BITS-1:0]  pad_right;
        t_mode                border_mode;
    } t_cfg;

    typedef struct packed {
        logic                  is_read;
        logic                  zero;
        logic                  border;
        logic                  bad;
        logic [ADDR_BITS-1:0]  addr;
        logic [PIXEL_BITS-1:0] pixel;
    } t_cmd;

endpackage

@@ rtl/ibp_cfg.sv @@
// ----------------------------------------------------------------------------
// ibp_cfg
// Configuration register file written through the valid/ready write channel.
// ----------------------------------------------------------------------------
module ibp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ibp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ibp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output ibp_pkg::t_cfg                      o_cfg
);

    ibp_pkg::t_cfg r_cfg;
    ibp_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (ibp_pkg::t_reg_idx'(i_cfg_index))
                ibp_pkg::REG_IMAGE_WIDTH:  n_cfg.image_width  = i_cfg_data;
                ibp_pkg::REG_IMAGE_HEIGHT: n_cfg.image_height = i_cfg_data;
                ibp_pkg::REG_PAD_TOP:      n_cfg.pad_top      = i_cfg_data[ibp_pkg::PAD_BITS-1:0];
                ibp_pkg::REG_PAD_BOTTOM:   n_cfg.pad_bottom   = i_cfg_data[ibp_pkg::PAD_BITS-1:0];
                ibp_pkg::REG_PAD_LEFT:     n_cfg.pad_left     = i_cfg_data[ibp_pkg::PAD_BITS-1:0];
                ibp_pkg::REG_PAD_RIGHT:    n_cfg.pad_right    = i_cfg_data[ibp_pkg::PAD_BITS-1:0];
                ibp_pkg::REG_BORDER_MODE:
                    n_cfg.border_mode = ibp_pkg::t_mode'(i_cfg_data[ibp_pkg::MODE_BITS-1:0]);
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= ibp_pkg::SIZE_BITS'(256);
            r_cfg.image_height <= ibp_pkg::SIZE_BITS'(256);
            r_cfg.pad_top      <= '0;
            r_cfg.pad_bottom   <= '0;
            r_cfg.pad_left     <= '0;
            r_cfg.pad_right    <= '0;
            r_cfg.border_mode  <= ibp_pkg::MODE_CONSTANT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/ibp_front.sv @@
// ----------------------------------------------------------------------------
// ibp_front
// Accepts input beats, maps padded positions back into the source image and
// classifies each item into a store command.
// ----------------------------------------------------------------------------
module ibp_front (
    input  ibp_pkg::t_cfg                      i_cfg,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [ibp_pkg::IDX_BITS-1:0]       i_row,
    input  logic [ibp_pkg::IDX_BITS-1:0]       i_col,
    input  logic [ibp_pkg::PIX_PORT_BITS-1:0]  i_pixel_in,
    input  logic                               i_q_full,
    output logic                               o_push,
    output ibp_pkg::t_cmd                      o_cmd
);

    localparam int KB = ibp_pkg::K_BITS;
    localparam int DB = ibp_pkg::DIM_BITS;
    localparam int AB = ibp_pkg::ADDR_BITS;

    function automatic logic [DB-1:0] clamp_size(logic [ibp_pkg::SIZE_BITS-1:0] v, int maxv);
        logic [DB-1:0] res;
        if (v == '0) begin
            res = DB'(1);
        end else if (32'(v) > maxv) begin
            res = DB'(maxv);
        end else begin
            res = DB'(v);
        end
        return res;
    endfunction

    function automatic logic [DB-1:0] map_axis(logic signed [KB-1:0] k, logic [DB-1:0] n,
                                               ibp_pkg::t_mode mode);
        logic signed [KB-1:0] ns;
        logic signed [KB-1:0] m;
        ns = signed'(KB'(n));
        m  = k;
        if (k < 0) begin
            if (mode == ibp_pkg::MODE_REFLECT) begin
                m = -k - KB'(1);
            end else if (mode == ibp_pkg::MODE_WRAP) begin
                m = k + ns;
            end
        end else if (k >= ns) begin
            if (mode == ibp_pkg::MODE_REFLECT) begin
                m = (ns <<< 1) - k - KB'(1);
            end else if (mode == ibp_pkg::MODE_WRAP) begin
                m = k - ns;
            end
        end
        if (m < 0) begin
            m = '0;
        end
        if (m > ns - KB'(1)) begin
            m = ns - KB'(1);
        end
        return DB'(unsigned'(m));
    endfunction

    logic [DB-1:0]        w;
    logic [DB-1:0]        h;
    logic [KB-1:0]        row_u;
    logic [KB-1:0]        col_u;
    logic signed [KB-1:0] kr;
    logic signed [KB-1:0] kc;
    logic [DB-1:0]        mr;
    logic [DB-1:0]        mc;
    logic                 load_ok;
    logic                 bad;
    logic                 border;
    logic                 accept;

    always_comb begin
        w       = clamp_size(i_cfg.image_width, ibp_pkg::MAX_WIDTH);
        h       = clamp_size(i_cfg.image_height, ibp_pkg::MAX_HEIGHT);
        row_u   = KB'(i_row);
        col_u   = KB'(i_col);
        load_ok = (row_u < KB'(h)) && (col_u < KB'(w));
        bad     = (row_u >= KB'(h) + KB'(i_cfg.pad_top) + KB'(i_cfg.pad_bottom)) ||
                  (col_u >= KB'(w) + KB'(i_cfg.pad_left) + KB'(i_cfg.pad_right));
        kr      = signed'(row_u) - signed'(KB'(i_cfg.pad_top));
        kc      = signed'(col_u) - signed'(KB'(i_cfg.pad_left));
        border  = (kr < 0) || (kr >= signed'(KB'(h))) || (kc < 0) || (kc >= signed'(KB'(w)));
        mr      = map_axis(kr, h, i_cfg.border_mode);
        mc      = map_axis(kc, w, i_cfg.border_mode);

        o_cmd.pixel = ibp_pkg::PIXEL_BITS'(i_pixel_in);
        if (ibp_pkg::t_opcode'(i_opcode) == ibp_pkg::OP_READ) begin
            o_cmd.is_read = 1'b1;
            o_cmd.bad     = bad;
            o_cmd.border  = border || bad;
            o_cmd.zero    = bad || (border && i_cfg.border_mode == ibp_pkg::MODE_CONSTANT);
            o_cmd.addr    = AB'(mr) * AB'(ibp_pkg::MAX_WIDTH) + AB'(mc);
        end else begin
            o_cmd.is_read = 1'b0;
            o_cmd.bad     = 1'b0;
            o_cmd.border  = 1'b0;
            o_cmd.zero    = 1'b0;
            o_cmd.addr    = AB'(row_u) * AB'(ibp_pkg::MAX_WIDTH) + AB'(col_u);
        end
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && (o_cmd.is_read || load_ok);

endmodule

@@ rtl/ibp_queue.sv @@
// ----------------------------------------------------------------------------
// ibp_queue
// Short command queue between the classifying front and the store back end.
// ----------------------------------------------------------------------------
`include "image_border_padding_top_defines.svh"

module ibp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ibp_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output ibp_pkg::t_cmd  o_cmd,
    output logic           o_empty
);

    localparam int DEPTH = ibp_pkg::QUEUE_DEPTH;
    localparam int PB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB    = $clog2(DEPTH + 1);

    ibp_pkg::t_cmd r_entry [DEPTH];
    logic [PB-1:0] r_wr_ptr;
    logic [PB-1:0] r_rd_ptr;
    logic [CB-1:0] r_count;
    logic [PB-1:0] n_wr_ptr;
    logic [PB-1:0] n_rd_ptr;
    logic [CB-1:0] n_count;

    assign o_full  = (r_count == CB'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PB'(DEPTH - 1)) ? '0 : r_wr_ptr + PB'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PB'(DEPTH - 1)) ? '0 : r_rd_ptr + PB'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CB'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    `IBP_ASSERT(a_count_bound, r_count <= CB'(DEPTH))
    `IBP_ASSERT(a_no_push_full, i_push |-> !o_full)
    `IBP_ASSERT(a_no_pop_empty, i_pop |-> !o_empty)

endmodule

@@ rtl/ibp_back.sv @@
// ----------------------------------------------------------------------------
// ibp_back
// Frame store and result register: carries out load and read commands.
// ----------------------------------------------------------------------------
module ibp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ibp_pkg::t_cmd                      i_cmd,
    input  logic                               i_q_empty,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ibp_pkg::PIX_PORT_BITS-1:0]  o_pixel_out,
    output logic                               o_in_border,
    output logic                               o_bad_position
);

    localparam int STORE_DEPTH = ibp_pkg::MAX_WIDTH * ibp_pkg::MAX_HEIGHT;

    logic [ibp_pkg::PIXEL_BITS-1:0] r_store [STORE_DEPTH];
    logic [ibp_pkg::PIXEL_BITS-1:0] r_rd_data;
    logic                           r_out_valid;
    logic                           r_zero;
    logic                           r_border;
    logic                           r_bad;

    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.is_read) begin
            r_store[i_cmd.addr] <= i_cmd.pixel;
        end
        if (o_pop && i_cmd.is_read && !i_cmd.zero) begin
            r_rd_data <= r_store[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= i_cmd.is_read;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_read) begin
            r_zero   <= i_cmd.zero;
            r_border <= i_cmd.border;
            r_bad    <= i_cmd.bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_zero ? '0 : ibp_pkg::PIX_PORT_BITS'(r_rd_data);
    assign o_in_border    = r_border;
    assign o_bad_position = r_bad;

endmodule

@@ rtl/image_border_padding_top.sv @@
// ----------------------------------------------------------------------------
// image_border_padding_top
// Frame store with constant, replicate, reflect and wrap border extension.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a load beat writes i_pixel_in at a
// source (i_row, i_col); loads outside the image are dropped without result.
// A read beat names a position of the padded image and yields one result
// beat on the output channel (o_out_valid / i_out_stall).
// Throughput: one item per cycle while i_out_stall is low, set by the single
// write/read port of the frame store, which takes one command each cycle.
// Read path: an accepted read beat enters the command queue, then leaves it
// with the registered store read into the result register that drives
// o_out_valid.
// Output stall: the result register holds, the two-entry command queue
// fills, and o_in_stall rises when the queue is full.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets sizes, pads
// and border mode; write it only while no item is in flight.
// Reset clears the queue, the result valid and the registers to a 256x256
// image, no padding, constant border. The frame store is not cleared: a
// pixel must be loaded before it is read.
// ----------------------------------------------------------------------------
module image_border_padding_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ibp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ibp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [ibp_pkg::IDX_BITS-1:0]       i_row,
    input  logic [ibp_pkg::IDX_BITS-1:0]       i_col,
    input  logic [ibp_pkg::PIX_PORT_BITS-1:0]  i_pixel_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ibp_pkg::PIX_PORT_BITS-1:0]  o_pixel_out,
    output logic                               o_in_border,
    output logic                               o_bad_position
);

    ibp_pkg::t_cfg cfg;
    ibp_pkg::t_cmd push_cmd;
    ibp_pkg::t_cmd pop_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    ibp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ibp_front u_front (
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_pixel_in (i_pixel_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    ibp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    ibp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (pop_cmd),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_out    (o_pixel_out),
        .o_in_border    (o_in_border),
        .o_bad_position (o_bad_position)
    );

endmodule

@@ tb/image_border_padding_checker.sv @@
// ----------------------------------------------------------------------------
// image_border_padding_checker
// Watches the configuration, input and result channels of the border padding
// block. Keeps its own copy of the registers and the source image, works out
// the padded pixel for every accepted read beat and compares each result
// beat, field by field, with the oldest outstanding read.
// ----------------------------------------------------------------------------
module image_border_padding_checker
    import ibp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_opcode,
    input  logic [IDX_BITS-1:0]        i_row,
    input  logic [IDX_BITS-1:0]        i_col,
    input  logic [PIX_PORT_BITS-1:0]   i_pixel_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [PIX_PORT_BITS-1:0]   i_pixel_out,
    input  logic                       i_in_border,
    input  logic                       i_bad_position,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PIX_PORT_BITS-1:0] pixel;
        logic                     in_border;
        logic                     bad_position;
    } t_padded_pixel;

    logic [PIXEL_BITS-1:0] source_image [MAX_WIDTH*MAX_HEIGHT];
    logic [SIZE_BITS-1:0]  cfg_width;
    logic [SIZE_BITS-1:0]  cfg_height;
    logic [PAD_BITS-1:0]   cfg_top;
    logic [PAD_BITS-1:0]   cfg_bottom;
    logic [PAD_BITS-1:0]   cfg_left;
    logic [PAD_BITS-1:0]   cfg_right;
    t_mode                 cfg_mode;
    t_padded_pixel         pending_reads[$];
    int                    fail_count = 0;
    int                    pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic int used_size(logic [SIZE_BITS-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic int fold_index(int k, int n, t_mode mode);
        if (k < 0) begin
            if (mode == MODE_REFLECT) k = -k - 1;
            else if (mode == MODE_WRAP) k = k + n;
        end else if (k >= n) begin
            if (mode == MODE_REFLECT) k = 2 * n - k - 1;
            else if (mode == MODE_WRAP) k = k - n;
        end
        if (k < 0) k = 0;
        if (k > n - 1) k = n - 1;
        return k;
    endfunction

    function automatic t_padded_pixel padded_pixel(int row, int col);
        int            w;
        int            h;
        int            kr;
        int            kc;
        t_padded_pixel r;
        w = used_size(cfg_width, MAX_WIDTH);
        h = used_size(cfg_height, MAX_HEIGHT);
        r = '0;
        if (row >= h + int'(cfg_top) + int'(cfg_bottom) ||
            col >= w + int'(cfg_left) + int'(cfg_right)) begin
            r.in_border    = 1'b1;
            r.bad_position = 1'b1;
            return r;
        end
        kr = row - int'(cfg_top);
        kc = col - int'(cfg_left);
        r.in_border = (kr < 0) || (kr >= h) || (kc < 0) || (kc >= w);
        if (!(r.in_border && cfg_mode == MODE_CONSTANT))
            r.pixel = source_image[fold_index(kr, h, cfg_mode) * MAX_WIDTH +
                                   fold_index(kc, w, cfg_mode)];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("%0t checker: %s got %0d want %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_padded_pixel want;
        if (!i_rst_n) begin
            cfg_width  = 9'd256;
            cfg_height = 9'd256;
            cfg_top    = '0;
            cfg_bottom = '0;
            cfg_left   = '0;
            cfg_right  = '0;
            cfg_mode   = MODE_CONSTANT;
            pending_reads.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_reads.size() == 0) begin
                    report_mismatch("result beat with no read outstanding:", 1, 0);
                end else begin
                    want = pending_reads.pop_front();
                    if (i_pixel_out !== want.pixel)
                        report_mismatch("pixel_out", i_pixel_out, want.pixel);
                    if (i_in_border !== want.in_border)
                        report_mismatch("in_border", i_in_border, want.in_border);
                    if (i_bad_position !== want.bad_position)
                        report_mismatch("bad_position", i_bad_position,
                                        want.bad_position);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  cfg_width  = i_cfg_data[SIZE_BITS-1:0];
                    REG_IMAGE_HEIGHT: cfg_height = i_cfg_data[SIZE_BITS-1:0];
                    REG_PAD_TOP:      cfg_top    = i_cfg_data[PAD_BITS-1:0];
                    REG_PAD_BOTTOM:   cfg_bottom = i_cfg_data[PAD_BITS-1:0];
                    REG_PAD_LEFT:     cfg_left   = i_cfg_data[PAD_BITS-1:0];
                    REG_PAD_RIGHT:    cfg_right  = i_cfg_data[PAD_BITS-1:0];
                    REG_BORDER_MODE:  cfg_mode   = t_mode'(i_cfg_data[MODE_BITS-1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_opcode == OP_READ)
                    pending_reads.push_back(padded_pixel(int'(i_row), int'(i_col)));
                else if (i_row < used_size(cfg_height, MAX_HEIGHT) &&
                         i_col < used_size(cfg_width, MAX_WIDTH))
                    source_image[int'(i_row) * MAX_WIDTH + int'(i_col)] =
                        i_pixel_in[PIXEL_BITS-1:0];
            end
        end
        pending_count = pending_reads.size();
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the image border padding block: a directed pass at the reset
// sizes, then phases over image sizes, pad widths and all four border modes.
// Phases with fill load the whole source image; all mix random reads inside
// and outside the padded image with in-image and dropped loads, under random
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ibp_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int IDX_TOP = 765;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_opcode = 1'b0;
    logic [IDX_BITS-1:0]        i_row = '0;
    logic [IDX_BITS-1:0]        i_col = '0;
    logic [PIX_PORT_BITS-1:0]   i_pixel_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [PIX_PORT_BITS-1:0]   o_pixel_out;
    logic                       o_in_border;
    logic                       o_bad_position;
    int                         fail_count;
    int                         reads_outstanding;
    int                         quiet_left = 0;
    int                         stall_hold = 0;

    image_border_padding_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_pixel_in     (i_pixel_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_out    (o_pixel_out),
        .o_in_border    (o_in_border),
        .o_bad_position (o_bad_position)
    );

    image_border_padding_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_pixel_in     (i_pixel_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_pixel_out    (o_pixel_out),
        .i_in_border    (o_in_border),
        .i_bad_position (o_bad_position),
        .o_fail_count   (fail_count),
        .o_pending      (reads_outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // alternate stall and free stretches on the result side
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
        end else if (!i_out_stall) begin
            i_out_stall <= 1'b1;
            stall_hold = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 8)
                                                      : $urandom_range(2, 0);
        end else begin
            i_out_stall <= 1'b0;
            stall_hold = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(4, 0);
        end
    end

    function automatic int pick_gap();
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        case ($urandom_range(19, 0))
            0: begin
                quiet_left = $urandom_range(50, 15);
                return 0;
            end
            1: return $urandom_range(24, 6);
            default: return ($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0;
        endcase
    endfunction

    // enter and leave at a falling edge
    task automatic send_item(t_opcode op, int row, int col, int pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_row      <= IDX_BITS'(row);
        i_col      <= IDX_BITS'(col);
        i_pixel_in <= PIX_PORT_BITS'(pix);
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] index, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_DATA_BITS'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (reads_outstanding > 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int top, int bottom, int left, int right,
                             t_mode mode, bit fill, int count);
        int ew;
        int eh;
        int prows;
        int pcols;
        int row;
        int col;
        t_opcode op;
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_PAD_TOP, top + 256 * $urandom_range(1, 0));
        write_reg(REG_PAD_BOTTOM, bottom + 256 * $urandom_range(1, 0));
        write_reg(REG_PAD_LEFT, left + 256 * $urandom_range(1, 0));
        write_reg(REG_PAD_RIGHT, right + 256 * $urandom_range(1, 0));
        write_reg(REG_BORDER_MODE, int'(mode) + 4 * $urandom_range(127, 0));
        write_reg(REG_UNUSED, $urandom_range(511, 0));
        i_cfg_valid <= 1'b0;
        ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        eh = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        prows = eh + top + bottom;
        pcols = ew + left + right;
        if (fill)
            for (int r = 0; r < eh; r++)
                for (int c = 0; c < ew; c++)
                    send_item(OP_LOAD, r, c, $urandom_range(255, 0));
        repeat (count) begin
            op  = OP_READ;
            row = $urandom_range(prows - 1, 0);
            col = $urandom_range(pcols - 1, 0);
            case ($urandom_range(9, 0))
                0: begin
                    op  = OP_LOAD;
                    row = $urandom_range(eh - 1, 0);
                    col = $urandom_range(ew - 1, 0);
                end
                1: begin
                    op = OP_LOAD;
                    if ($urandom_range(1, 0)) begin
                        row = $urandom_range(IDX_TOP, eh);
                        col = $urandom_range(IDX_TOP, 0);
                    end else begin
                        row = $urandom_range(IDX_TOP, 0);
                        col = $urandom_range(IDX_TOP, ew);
                    end
                end
                2: begin
                    if (prows <= IDX_TOP && (pcols > IDX_TOP || $urandom_range(1, 0))) begin
                        row = $urandom_range(IDX_TOP, prows);
                        col = $urandom_range(IDX_TOP, 0);
                    end else if (pcols <= IDX_TOP) begin
                        row = $urandom_range(IDX_TOP, 0);
                        col = $urandom_range(IDX_TOP, pcols);
                    end
                end
                default: ;
            endcase
            send_item(op, row, col, $urandom_range(255, 0));
        end
        settle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners of the full-size image at reset settings
        send_item(OP_LOAD, 0, 0, 8'h00);
        send_item(OP_LOAD, 255, 255, 8'hFF);
        send_item(OP_LOAD, 0, 255, 8'hA5);
        send_item(OP_LOAD, 255, 0, 8'h5A);
        send_item(OP_LOAD, 256, 0, 8'h11);
        send_item(OP_LOAD, 0, 256, 8'h22);
        send_item(OP_LOAD, IDX_TOP, IDX_TOP, 8'h33);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 255, 255, 8'hFF);
        send_item(OP_READ, 0, 255, 0);
        send_item(OP_READ, 255, 0, 0);
        send_item(OP_READ, 256, 0, 0);
        send_item(OP_READ, 0, IDX_TOP, 0);
        send_item(OP_READ, IDX_TOP, IDX_TOP, 0);
        settle();

        run_phase(4, 3, 2, 2, 3, 3, MODE_CONSTANT, 1'b1, 40);
        run_phase(4, 3, 5, 7, 6, 2, MODE_REPLICATE, 1'b1, 40);
        run_phase(5, 4, 3, 6, 4, 7, MODE_REFLECT, 1'b1, 40);
        run_phase(3, 5, 4, 4, 9, 2, MODE_WRAP, 1'b1, 40);
        run_phase(1, 1, 255, 255, 255, 255, MODE_REFLECT, 1'b1, 35);
        run_phase(256, 0, 0, 3, 255, 0, MODE_REPLICATE, 1'b1, 25);
        run_phase(0, 64, 255, 0, 0, 1, MODE_WRAP, 1'b1, 25);
        run_phase(400, 1, 2, 3, 255, 255, MODE_WRAP, 1'b0, 35);
        run_phase(2, 2, 0, 0, 0, 0, MODE_CONSTANT, 1'b1, 25);

        if (fail_count == 0 && reads_outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ibp_pkg.sv
rtl/ibp_cfg.sv
rtl/ibp_front.sv
rtl/ibp_queue.sv
rtl/ibp_back.sv
rtl/image_border_padding_top.sv
tb/image_border_padding_checker.sv
tb/testbench.sv
